/* hdl/fir_filter_circular_q15_assert.svh */
// Assertion macros for the checker file of the FIR filter.
// No dependencies; included by bare file name.
`ifndef FIR_FILTER_CIRCULAR_Q15_ASSERT_SVH
`define FIR_FILTER_CIRCULAR_Q15_ASSERT_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define FIRCQ15_ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the checker's own clock and reset.
`define FIRCQ15_ASSERT(label, prop, msg) \
   `FIRCQ15_ASSERT_AT(label, clock, reset, prop, msg)

`endif

/* hdl/fircq15_pkg.sv */
// Package for the 33-tap Q15 FIR filter: tap constants, coefficient table,
// control types and the sequencer state encoding. No dependencies.
package fircq15_pkg;

   localparam int TAP_COUNT = 33;
   localparam int TAP_IDX_W = $clog2(TAP_COUNT);
   localparam int COEF_W    = 14;
   localparam int OUT_W     = 32;
   localparam int GUARD_W   = $clog2(TAP_COUNT);

   localparam logic [TAP_IDX_W-1:0] TAP_LAST = TAP_IDX_W'(TAP_COUNT - 1);

   // Symmetric low-pass coefficients, Q15. Entry 0 weights the newest sample.
   localparam logic signed [COEF_W-1:0] COEF_TABLE [TAP_COUNT] = '{
      -14'sd31,  14'sd0,    14'sd50,   14'sd120,  14'sd177,  14'sd158,
      14'sd0,    -14'sd307, -14'sd669, -14'sd892, -14'sd731, 14'sd0,
      14'sd1326, 14'sd3049, 14'sd4784, 14'sd6074, 14'sd6550, 14'sd6074,
      14'sd4784, 14'sd3049, 14'sd1326, 14'sd0,    -14'sd731, -14'sd892,
      -14'sd669, -14'sd307, 14'sd0,    14'sd158,  14'sd177,  14'sd120,
      14'sd50,   14'sd0,    -14'sd31
   };

   // Flags that travel with one tap through the multiply-accumulate pipe.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

/* hdl/fircq15_if.sv */
// Valid/ready channel interfaces for the FIR filter's request and result.
// Depends on fircq15_pkg for the result width.
interface fircq15_req_if #(parameter int WIDTH = 16) ();
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface fircq15_rsp_if import fircq15_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] filtered_out;

   modport source (output valid, output filtered_out, input ready);
   modport sink   (input valid, input filtered_out, output ready);
endinterface

/* hdl/fircq15_mac.sv */
// Shared multiply-accumulate unit: one registered product, one accumulator.
// Depends on fircq15_pkg.
module fircq15_mac import fircq15_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mac_ctrl_type                   ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic signed [COEF_W-1:0]       coef,
   output logic                           done,
   output logic signed [OUT_W-1:0]        acc_out
);

   localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
   localparam int ACC_W  = (PROD_W + GUARD_W > OUT_W) ? PROD_W + GUARD_W : OUT_W;

   mac_ctrl_type              prod_ctrl_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic                      done_ff;

   // Both operands are sign-extended to the full product width first.
   assign prod_in  = PROD_W'(sample) * PROD_W'(coef);
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_in   = prod_ctrl_ff.first ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctrl_ff <= '0;
         done_ff      <= 1'b0;
      end else begin
         prod_ctrl_ff <= ctrl;
         done_ff      <= prod_ctrl_ff.valid && prod_ctrl_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.valid) begin
         prod_ff <= prod_in;
      end
      if (prod_ctrl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign done    = done_ff;
   assign acc_out = acc_ff[OUT_W-1:0];

endmodule

/* hdl/fir_filter_circular_q15.sv */
// 33-tap direct-form low-pass FIR filter on signed Q15 samples with a circular
// delay line held in a synchronous memory. Each request carries one sample; it
// is written at the write pointer and the block then walks all 33 taps through
// one shared multiply-accumulate unit, one tap per cycle, and returns one
// signed Q30 result (low 32 bits of the 36-bit accumulator, no saturation).
// A result becomes valid once the tap reads have passed the read, multiply
// and accumulate registers of the pipeline and the drain and result hand-off
// states; the next request is accepted only after that hand-off, so the block
// takes no new sample while one is still being filtered. A finished result sits
// in the output register, so a new request is taken while it waits; the block
// only stalls at the end of the next computation if that result is still not
// taken. The delay line needs no clearing pass after reset: one valid flag per
// entry is cleared by reset and an entry never written reads as zero.
// Depends on fircq15_pkg, fircq15_if and fircq15_mac.
module fir_filter_circular_q15 import fircq15_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   fircq15_req_if.sink   req_if,
   fircq15_rsp_if.source rsp_if
);

   // Delay line memory: one write port (new sample on request), one read port
   // (tap walk). Writes happen only in the idle state and reads only in the
   // run state, so the two never touch the same entry in one cycle.
   logic signed [SAMPLE_WIDTH-1:0] line_mem [TAP_COUNT];

   logic [TAP_COUNT-1:0] line_valid_ff, line_valid_in;
   logic [TAP_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [TAP_IDX_W-1:0] pos_ff, pos_in;
   logic [TAP_IDX_W-1:0] tap_ff, tap_in;
   state_type            state_ff, state_in;

   // Read stage: memory data, its valid flag and the matching coefficient.
   logic signed [SAMPLE_WIDTH-1:0] rd_data_ff;
   logic                           rd_valid_ff;
   logic signed [COEF_W-1:0]       coef_ff;
   mac_ctrl_type                   mac_ctrl_ff, mac_ctrl_in;
   logic signed [SAMPLE_WIDTH-1:0] tap_sample;

   logic                    mac_done;
   logic signed [OUT_W-1:0] mac_acc;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_data_ff;

   logic req_accept;
   logic issue;
   logic rsp_load;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign issue        = (state_ff == ST_RUN);
   assign rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   // Sequencer: capture the sample, walk the taps from the newest sample
   // toward older ones, wait for the pipeline to drain, then hand off.
   always_comb begin
      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      pos_in        = pos_ff;
      tap_in        = tap_ff;
      line_valid_in = line_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               line_valid_in[wr_ptr_ff] = 1'b1;
               pos_in    = wr_ptr_ff;
               tap_in    = '0;
               wr_ptr_in = (wr_ptr_ff == '0) ? TAP_LAST : wr_ptr_ff - 1'b1;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            pos_in = (pos_ff == TAP_LAST) ? '0 : pos_ff + 1'b1;
            tap_in = tap_ff + 1'b1;
            if (tap_ff == TAP_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mac_ctrl_in.valid = issue;
      mac_ctrl_in.first = issue && (tap_ff == '0);
      mac_ctrl_in.last  = issue && (tap_ff == TAP_LAST);
   end

   // The output register holds a result until it is taken; a new one is
   // loaded in the same cycle the old one leaves.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_ptr_ff     <= '0;
         pos_ff        <= '0;
         tap_ff        <= '0;
         line_valid_ff <= '0;
         mac_ctrl_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         pos_ff        <= pos_in;
         tap_ff        <= tap_in;
         line_valid_ff <= line_valid_in;
         mac_ctrl_ff   <= mac_ctrl_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         line_mem[wr_ptr_ff] <= req_if.sample_in;
      end
      if (issue) begin
         rd_data_ff  <= line_mem[pos_ff];
         rd_valid_ff <= line_valid_ff[pos_ff];
         coef_ff     <= COEF_TABLE[tap_ff];
      end
      if (rsp_load) begin
         rsp_data_ff <= mac_acc;
      end
   end

   // An entry never written since reset contributes zero.
   assign tap_sample = rd_valid_ff ? rd_data_ff : '0;

   fircq15_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl_ff),
      .sample  (tap_sample),
      .coef    (coef_ff),
      .done    (mac_done),
      .acc_out (mac_acc)
   );

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.filtered_out = rsp_data_ff;

endmodule

/* hdl/fircq15_checker.sv */
// Port-level checker for the FIR filter and its bind to the top level.
// Depends on fir_filter_circular_q15_assert.svh and fir_filter_circular_q15.
`include "fir_filter_circular_q15_assert.svh"

module fircq15_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] filtered_out
);

   // A stalled result keeps its value until it is taken.
   `FIRCQ15_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(filtered_out), "result changed while stalled")

   // The block works on one request at a time.
   `FIRCQ15_ASSERT(a_busy_after_req, req_valid && req_ready |=> !req_ready, "request taken while busy")

   // The tap walk keeps the block busy, so ready is still low well after a request.
   `FIRCQ15_ASSERT(a_busy_during_walk, req_valid && req_ready |-> ##32 !req_ready, "tap walk ended too early")

   // A fresh result is loaded only at the end of a computation, never while idle.
   `FIRCQ15_ASSERT(a_rsp_from_work, $rose(rsp_valid) |-> !$past(req_ready), "result appeared while idle")

endmodule

bind fir_filter_circular_q15 fircq15_checker u_fircq15_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .filtered_out (rsp_if.filtered_out)
);

/* bench/fir_filter_circular_q15_tb.sv */
// Self-checking bench for the 33-tap Q15 FIR filter: a behavioral filter in a
// scoreboard class predicts every Q30 sum while tasks drive random traffic.
// Depends on fircq15_pkg, fircq15_if and the fir_filter_circular_q15 RTL.
`timescale 1ns / 1ps

module fir_filter_circular_q15_tb;
   import fircq15_pkg::*;

   localparam int SAMPLE_W      = 16;
   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 6;
   // Margin at the end of the run, after every predicted sum has been returned.
   localparam int DRAIN_CYCLES  = 50;
   // Cycles without any accepted request or result before the run is called dead.
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 615;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   // Kinds of signal segment used by the random part of the run.
   typedef enum int {
      SEG_NOISE,
      SEG_PEAK,
      SEG_IMPULSE,
      SEG_STEP,
      SEG_TINY,
      SEG_ALTERNATE
   } segment_kind_type;

   // The scoreboard keeps its own copy of the delay line and write pointer and
   // computes the filter sum for each accepted request, in request order.
   class fir_sum_board;
      logic signed [SAMPLE_W-1:0] history [TAP_COUNT];
      int unsigned                head;
      logic signed [OUT_W-1:0]    expected_sums [$];
      int unsigned                mismatch_count;

      function new();
         foreach (history[i]) history[i] = '0;
         head           = 0;
         mismatch_count = 0;
      endfunction

      // Store the sample at the head, weight the newest sample by coefficient 0
      // and walk toward older samples, then step the head back with wrap.
      function logic signed [OUT_W-1:0] filter_sample(logic signed [SAMPLE_W-1:0] sample);
         longint      acc;
         int unsigned pos;
         history[head] = sample;
         acc = 0;
         pos = head;
         for (int k = 0; k < TAP_COUNT; k++) begin
            acc += longint'(history[pos]) * longint'(COEF_TABLE[k]);
            pos = (pos == TAP_COUNT - 1) ? 0 : pos + 1;
         end
         head = (head == 0) ? TAP_COUNT - 1 : head - 1;
         return acc[OUT_W-1:0];
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] sample);
         expected_sums.push_back(filter_sample(sample));
      endfunction

      function void check_sum(logic signed [OUT_W-1:0] actual);
         logic signed [OUT_W-1:0] wanted;
         if (expected_sums.size() == 0) begin
            $error("filtered_out: no result expected, actual %0d", actual);
            mismatch_count++;
            return;
         end
         wanted = expected_sums.pop_front();
         if (actual !== wanted) begin
            $error("filtered_out: expected %0d, actual %0d", wanted, actual);
            mismatch_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_sums.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   fircq15_req_if #(.WIDTH(SAMPLE_W)) req_ch ();
   fircq15_rsp_if                     rsp_ch ();

   fir_filter_circular_q15 #(
      .SAMPLE_WIDTH(SAMPLE_W)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   fir_sum_board sum_board = new();

   // Idle rates in percent for the current phase. While calm is set, neither
   // side idles, which gives stretches of back-to-back traffic.
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   logic        calm;
   int unsigned quiet_cycles;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // The result side: ready is redrawn at every falling edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Both channels are observed at the rising edge. The result is checked
   // before the new request is noted; a result always belongs to an older
   // request, so the order only matters for the empty-queue case.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            sum_board.check_sum(rsp_ch.filtered_out);
         end
         if (req_ch.valid && req_ch.ready) begin
            sum_board.note_sample(req_ch.sample_in);
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Watchdog: a long stretch with no handshake on either side ends the run.
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("fir_filter_circular_q15_tb: done, errors");
      $finish;
   end

   // Offers one sample, possibly after some idle cycles, and returns at the
   // falling edge after the request was accepted. Valid stays high into the
   // next call unless that call starts with an idle cycle, so it is never
   // lowered and raised within one time step.
   task automatic send_sample(logic signed [SAMPLE_W-1:0] sample);
      while (!calm && ($urandom_range(0, 99) < send_idle_pct)) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= sample;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Holds the request side idle until every predicted sum has been returned.
   task automatic wait_for_empty();
      req_ch.valid <= 1'b0;
      while (sum_board.pending() != 0) @(negedge clock);
   endtask

   // A sample whose sign matches the coefficient it will meet at the peak
   // instants (opposes it with flip set), so the sum peaks in magnitude every 33
   // requests. Zero coefficients get a random sample since they do not matter.
   function automatic logic signed [SAMPLE_W-1:0] peak_sample(int unsigned idx, logic flip);
      logic signed [COEF_W-1:0]   coef;
      logic signed [SAMPLE_W-1:0] sample;
      coef = COEF_TABLE[(TAP_COUNT - (idx % TAP_COUNT)) % TAP_COUNT];
      if (coef == 0) begin
         sample = SAMPLE_W'($urandom);
      end else begin
         sample = ((coef < 0) ^ flip) ? SAMPLE_MIN : SAMPLE_MAX;
      end
      return sample;
   endfunction

   // Random part of one phase: a chain of signal segments, each a short
   // stretch of a recognizable shape with random content. Now and then the
   // sender waits for the block to drain completely before the next segment.
   task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int unsigned items);
      int unsigned                sent;
      int unsigned                seg_len;
      segment_kind_type           kind;
      logic                       flip;
      logic signed [SAMPLE_W-1:0] level;
      logic signed [SAMPLE_W-1:0] sample;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < items) begin
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 11) == 0) begin
            wait_for_empty();
         end
         kind  = segment_kind_type'($urandom_range(0, 5));
         flip  = 1'($urandom_range(0, 1));
         level = SAMPLE_W'($urandom);
         case (kind)
            SEG_PEAK:    seg_len = $urandom_range(40, 70);
            SEG_IMPULSE: seg_len = $urandom_range(34, 40);
            SEG_STEP:    seg_len = $urandom_range(20, 50);
            default:     seg_len = $urandom_range(10, 40);
         endcase
         // The last segment of a phase is cut so the phase sends its exact count.
         if (seg_len > items - sent) begin
            seg_len = items - sent;
         end
         for (int i = 0; i < seg_len; i++) begin
            case (kind)
               SEG_PEAK:      sample = peak_sample(i, flip);
               SEG_IMPULSE:   sample = (i == 0) ? level : '0;
               SEG_STEP:      sample = level;
               SEG_TINY:      sample = SAMPLE_W'($urandom_range(0, 8)) - 16'sd4;
               SEG_ALTERNATE: sample = ((i % 2 == 1) ^ flip) ? SAMPLE_MIN : SAMPLE_MAX;
               default:       sample = SAMPLE_W'($urandom);
            endcase
            send_sample(sample);
         end
         sent += seg_len;
      end
      calm = 1'b0;
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] opening [$];
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.sample_in = '0;
      calm             = 1'b0;
      send_idle_pct    = 19;
      recv_idle_pct    = 45;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Opening requests: both extremes, values near zero, alternating bit
      // patterns, and full-scale swings. The first request already makes the
      // write pointer wrap from 0 to 32.
      opening = '{16'sd0, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 16'sd1, -16'sd1,
                  16'sd0, 16'sh5555, 16'shAAAA, -16'sd2, 16'sd256, SAMPLE_MIN, SAMPLE_MIN,
                  SAMPLE_MAX, SAMPLE_MAX, 16'sh0001, 16'sh8001, 16'sd0};
      foreach (opening[i]) send_sample(opening[i]);

      // Pause with a full pipeline drained before the random traffic starts.
      wait_for_empty();

      run_phase(19, 45, PHASE_ITEMS);
      run_phase(45, 19, PHASE_ITEMS);
      run_phase(0, 0, PHASE_ITEMS);

      req_ch.valid <= 1'b0;
      while (sum_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sum_board.mismatch_count == 0 && sum_board.pending() == 0) begin
         $display("fir_filter_circular_q15_tb: done, clean");
      end else begin
         $display("fir_filter_circular_q15_tb: done, errors");
      end
      $finish;
   end

endmodule
